// ----- rtl/core/skt_pkg.sv -----
// Package: shared constants, codes and cell command type for the sorted key table.
package skt_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                    ins_en;
        logic                    rem_en;
        logic signed [KEY_W-1:0] key;
    } t_cell_cmd;

endpackage

// ----- rtl/core/sorted_key_table.sv -----
// Top level: sorted multiset of signed keys built as a chain of compare-and-shift cells.
// The result strobe rises in the cycle after the transaction is taken.
// Throughput: one transaction per cycle; busy stays low, set by the key broadcast to all cells.
// The receiver cannot stall; each result is shown for exactly one cycle on o_valid.
// Synchronous active-low reset clears the entry count and strobe; slot contents are not cleared.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_action,
    input  logic signed [skt_pkg::KEY_W-1:0]     i_key,
    output logic                                 o_valid,
    output logic [skt_pkg::STATUS_W-1:0]         o_status,
    output logic [skt_pkg::COUNT_OUT_W-1:0]      o_count_after,
    output logic                                 o_is_empty,
    output logic signed [skt_pkg::KEY_W-1:0]     o_head_key
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                              accept;
    logic                              full;
    logic                              found;
    skt_pkg::t_cell_cmd                cmd;
    logic [CAPACITY-1:0]               cell_ge;
    logic [CAPACITY-1:0]               cell_hit;
    logic [CAPACITY-1:0]               cell_occ;
    logic signed [skt_pkg::KEY_W-1:0]  cell_key [CAPACITY];

    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    logic                              r_valid;
    logic [skt_pkg::STATUS_W-1:0]      r_status;
    logic [skt_pkg::STATUS_W-1:0]      n_status;
    logic [CNT_W+skt_pkg::COUNT_OUT_W-1:0] count_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign found  = |cell_hit;

    assign cmd.key    = i_key;
    assign cmd.ins_en = accept && (i_action == skt_pkg::ACT_INSERT) && !full;
    assign cmd.rem_en = accept && (i_action == skt_pkg::ACT_REMOVE) && found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign cell_occ[g] = (CNT_W'(g) < r_count);
            skt_cell u_cell (
                .i_clk      (i_clk),
                .i_cmd      (cmd),
                .i_occupied (cell_occ[g]),
                .i_prev_ge  ((g == 0) ? 1'b0 : cell_ge[(g == 0) ? 0 : g-1]),
                .i_prev_key (cell_key[(g == 0) ? 0 : g-1]),
                .i_next_key (cell_key[(g == CAPACITY-1) ? g : g+1]),
                .o_ge       (cell_ge[g]),
                .o_hit      (cell_hit[g]),
                .o_key      (cell_key[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = skt_pkg::ST_OK;
        if (i_action == skt_pkg::ACT_INSERT) begin
            if (full) begin
                n_status = skt_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (found) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                n_status = skt_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    assign count_ext     = {{skt_pkg::COUNT_OUT_W{1'b0}}, r_count};
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_count_after = count_ext[skt_pkg::COUNT_OUT_W-1:0];
    assign o_is_empty    = (r_count == '0);
    assign o_head_key    = o_is_empty ? '0 : cell_key[0];

endmodule

// ----- rtl/core/skt_cell.sv -----
// One slot of the sorted chain: holds a key, compares it and shifts with its neighbours.
module skt_cell (
    input  logic                           i_clk,
    input  skt_pkg::t_cell_cmd             i_cmd,
    input  logic                           i_occupied,
    input  logic                           i_prev_ge,
    input  logic signed [skt_pkg::KEY_W-1:0] i_prev_key,
    input  logic signed [skt_pkg::KEY_W-1:0] i_next_key,
    output logic                           o_ge,
    output logic                           o_hit,
    output logic signed [skt_pkg::KEY_W-1:0] o_key
);

    logic signed [skt_pkg::KEY_W-1:0] r_key;
    logic signed [skt_pkg::KEY_W-1:0] n_key;

    // ge: this slot holds a key not below the transaction key
    assign o_ge  = i_occupied && !(r_key < i_cmd.key);
    assign o_hit = o_ge && !i_prev_ge && (r_key == i_cmd.key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins_en) begin
            if (i_prev_ge) begin
                n_key = i_prev_key;
            end else if (o_ge || !i_occupied) begin
                n_key = i_cmd.key;
            end
        end else if (i_cmd.rem_en && o_ge) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
